// ----- rtl/shp_pkg.sv -----
// shared types, constants and round function for the siphash-2-4 unit
// no dependencies; imported by front, core, digest queue, top level and testbench
`default_nettype none

package shp_pkg;

    localparam logic [63:0] INIT_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_C3 = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;
    localparam int LEN_SHIFT = 56;
    localparam logic [3:0] FULL_BYTES = 4'd8;

    // work queue between front and core
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // digest queue at the output
    localparam int ODEPTH = 2;
    localparam int OPTR_W = $clog2(ODEPTH);
    localparam int OCNT_W = $clog2(ODEPTH + 1);

    typedef enum logic [0:0] {
        CFG_KEY_LOW  = 1'b0,
        CFG_KEY_HIGH = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ENT_MSG       = 2'd0,
        ENT_LAST_FULL = 2'd1,
        ENT_LAST_PART = 2'd2
    } ent_op_t;

    // one classified item: word is the full message word, tail the final block
    typedef struct packed {
        ent_op_t     op;
        logic [63:0] word;
        logic [63:0] tail;
    } shp_entry_t;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } shp_state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic shp_state_t sip_round(input shp_state_t s);
        shp_state_t r;
        r = s;
        r.v0 = r.v0 + r.v1;
        r.v1 = rotl64(r.v1, 13) ^ r.v0;
        r.v0 = rotl64(r.v0, 32);
        r.v2 = r.v2 + r.v3;
        r.v3 = rotl64(r.v3, 16) ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = rotl64(r.v3, 21) ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = rotl64(r.v1, 17) ^ r.v2;
        r.v2 = rotl64(r.v2, 32);
        return r;
    endfunction

    function automatic shp_state_t sip_init(input logic [63:0] klo, input logic [63:0] khi);
        shp_state_t r;
        r.v0 = klo ^ INIT_C0;
        r.v1 = khi ^ INIT_C1;
        r.v2 = klo ^ INIT_C2;
        r.v3 = khi ^ INIT_C3;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/shp_front.sv -----
// front end: accepts message words, tracks length, builds final blocks
// and queues classified items for the core; uses shp_pkg
`default_nettype none

module shp_front
    import shp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] message_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        last_word,
    input  wire logic        cfg_we,
    output logic             q_valid,
    output shp_entry_t       q_entry,
    input  wire logic        q_take
);

    shp_entry_t         ent_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]         length_reg, length_next;

    logic               acc;
    logic [3:0]         n_sat;
    logic [7:0]         len_plus_n;
    logic [7:0]         len_plus_8;
    logic [63:0]        masked;
    shp_entry_t         new_ent;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = ent_mem_reg[rd_ptr_reg];
    assign acc     = push && !full;

    assign n_sat      = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
    assign len_plus_n = length_reg + {4'd0, n_sat};
    assign len_plus_8 = length_reg + {4'd0, FULL_BYTES};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            masked[i*8 +: 8] = (4'(i) < n_sat) ? message_word[i*8 +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        new_ent.word = message_word;
        new_ent.tail = '0;
        new_ent.op   = ENT_MSG;
        length_next  = length_reg;
        if (!last_word)
        begin
            new_ent.op  = ENT_MSG;
            length_next = len_plus_8;
        end
        else if (n_sat == FULL_BYTES)
        begin
            // full last word, then a block holding only the length
            new_ent.op   = ENT_LAST_FULL;
            new_ent.tail = {len_plus_8, 56'd0};
            length_next  = '0;
        end
        else
        begin
            new_ent.op   = ENT_LAST_PART;
            new_ent.tail = masked | ({56'd0, len_plus_n} << LEN_SHIFT);
            length_next  = '0;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (acc)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_take && q_valid)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({acc, q_take && q_valid})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            length_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            if (cfg_we)
            begin
                length_reg <= '0;
            end
            else if (acc)
            begin
                length_reg <= length_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ent_mem_reg[wr_ptr_reg] <= new_ent;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/shp_core.sv -----
// back end: key registers and the mixing state, one sip round per cycle
// over compression and finalization unless a full digest queue holds it; uses shp_pkg
`default_nettype none

module shp_core
    import shp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        q_valid,
    input  wire shp_entry_t  q_entry,
    output logic             q_take,
    input  wire logic        out_full,
    output logic             out_push,
    output logic [63:0]      out_digest
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABS,
        ST_FIN
    } core_st_t;

    core_st_t    st_reg, st_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [63:0] blk_reg, blk_next;
    logic [63:0] tail_reg, tail_next;
    logic        more_reg, more_next;
    logic        fin_reg, fin_next;
    shp_state_t  v_reg, v_next;
    logic [63:0] key_lo_reg, key_lo_next;
    logic [63:0] key_hi_reg, key_hi_next;

    shp_state_t  rin;
    shp_state_t  rout;

    always_comb
    begin
        rin = v_reg;
        if (st_reg == ST_ABS && cnt_reg == 2'd0)
        begin
            rin.v3 = v_reg.v3 ^ blk_reg;
        end
        rout = sip_round(rin);
    end

    assign out_digest = rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;

    always_comb
    begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        blk_next    = blk_reg;
        tail_next   = tail_reg;
        more_next   = more_reg;
        fin_next    = fin_reg;
        v_next      = v_reg;
        key_lo_next = key_lo_reg;
        key_hi_next = key_hi_reg;
        q_take      = 1'b0;
        out_push    = 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                end
            end
            ST_ABS:
            begin
                v_next = rout;
                if (cnt_reg == 2'd0)
                begin
                    cnt_next = 2'd1;
                end
                else
                begin
                    v_next.v0 = rout.v0 ^ blk_reg;
                    cnt_next  = 2'd0;
                    if (more_reg)
                    begin
                        blk_next  = tail_reg;
                        more_next = 1'b0;
                    end
                    else if (fin_reg)
                    begin
                        v_next.v2 = rout.v2 ^ FINAL_XOR;
                        st_next   = ST_FIN;
                    end
                    else if (q_valid)
                    begin
                        q_take = 1'b1;
                    end
                    else
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_FIN:
            begin
                if (cnt_reg != 2'd3)
                begin
                    v_next   = rout;
                    cnt_next = cnt_reg + 2'd1;
                end
                else if (!out_full)
                begin
                    // last round: digest out, state back to the key
                    out_push = 1'b1;
                    v_next   = sip_init(key_lo_reg, key_hi_reg);
                    cnt_next = 2'd0;
                    if (q_valid)
                    begin
                        q_take = 1'b1;
                    end
                    else
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        if (q_take)
        begin
            st_next   = ST_ABS;
            cnt_next  = 2'd0;
            blk_next  = (q_entry.op == ENT_LAST_PART) ? q_entry.tail : q_entry.word;
            tail_next = q_entry.tail;
            more_next = (q_entry.op == ENT_LAST_FULL);
            fin_next  = (q_entry.op != ENT_MSG);
        end

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_KEY_LOW:  key_lo_next = cfg_data;
                CFG_KEY_HIGH: key_hi_next = cfg_data;
                default:      key_lo_next = key_lo_reg;
            endcase
            v_next = sip_init(key_lo_next, key_hi_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            cnt_reg    <= '0;
            more_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            key_lo_reg <= '0;
            key_hi_reg <= '0;
            v_reg      <= sip_init(64'd0, 64'd0);
        end
        else
        begin
            st_reg     <= st_next;
            cnt_reg    <= cnt_next;
            more_reg   <= more_next;
            fin_reg    <= fin_next;
            key_lo_reg <= key_lo_next;
            key_hi_reg <= key_hi_next;
            v_reg      <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

// ----- rtl/shp_outq.sv -----
// small digest queue between the core and the result ports
// uses shp_pkg for depth constants
`default_nettype none

module shp_outq
    import shp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr,
    input  wire logic [63:0] wr_data,
    output logic             full,
    output logic             empty,
    input  wire logic        rd,
    output logic [63:0]      rd_data
);

    logic [63:0]       dat_mem_reg [ODEPTH];
    logic [OPTR_W-1:0] wr_ptr_reg;
    logic [OPTR_W-1:0] rd_ptr_reg;
    logic [OCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (cnt_reg == OCNT_W'(ODEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = dat_mem_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;

    always_comb
    begin
        case ({do_wr, do_rd})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            dat_mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/siphash_2_4_keyed_hash_unit.sv -----
// top level of the siphash-2-4 unit: front, core and digest queue
// depends on shp_pkg, shp_front, shp_core, shp_outq
//
//   port group     | direction | handshake
//   message items  | in        | push / full (message_word, valid_bytes, last_word)
//   digest items   | out       | pop / empty (digest)
//   key writes     | in        | cfg_we, cfg_index, cfg_data
//
// the core runs one sip round per cycle unless a full digest queue holds
// it: a word takes the compression rounds of siphash-2-4; a last word adds
// those of any extra block plus 4 finalization rounds.
// a 4-entry work queue takes items every cycle, unless full, while the core is busy.
// reset loads the state from an all-zero key; a key write reloads it.
// a full digest queue holds the core on its last finalization round.
`default_nettype none

module siphash_2_4_keyed_hash_unit
    import shp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] message_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        last_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      digest,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic        q_valid;
    shp_entry_t  q_entry;
    logic        q_take;
    logic        o_full;
    logic        o_push;
    logic [63:0] o_digest;

    shp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .cfg_we       (cfg_we),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_take       (q_take)
    );

    shp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_take     (q_take),
        .out_full   (o_full),
        .out_push   (o_push),
        .out_digest (o_digest)
    );

    shp_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (o_push),
        .wr_data (o_digest),
        .full    (o_full),
        .empty   (empty),
        .rd      (pop),
        .rd_data (digest)
    );

endmodule

`default_nettype wire

// ----- rtl/shp_checker.sv -----
// port-level checks for the siphash-2-4 unit, bound to the top level
// depends only on the top level's ports
`default_nettype none

module shp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [63:0] digest
);

    // a waiting digest holds until taken
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest)))
        else $error("digest changed or vanished while waiting");

    // the core runs compression and finalization rounds between two digests, so a fresh one taken at once leaves empty
    a_digest_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && $past(empty)) |=> empty)
        else $error("two digests produced too close together");

    // the work queue only fills through an accepted item
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an item pushed");

    // queues come out of reset empty
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

endmodule

bind siphash_2_4_keyed_hash_unit shp_checker u_shp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .digest (digest)
);

`default_nettype wire

// ----- tb/siphash_2_4_keyed_hash_unit_test.sv -----
// self-checking testbench for the siphash-2-4 keyed hash unit: directed and random messages
// under several keys, with random gaps on the message and digest sides
// depends on shp_pkg (key register indexes) and siphash_2_4_keyed_hash_unit
module siphash_2_4_keyed_hash_unit_test;
    import shp_pkg::*;

    localparam logic [63:0] SEED_A = 64'h736f6d6570736575;
    localparam logic [63:0] SEED_B = 64'h646f72616e646f6d;
    localparam logic [63:0] SEED_C = 64'h6c7967656e657261;
    localparam logic [63:0] SEED_D = 64'h7465646279746573;
    localparam logic [63:0] FINISH_MARK = 64'h00000000000000ff;
    localparam logic [63:0] ALL_ONES = 64'hffffffffffffffff;
    localparam int SETTLE_CYCLES = 64;
    localparam int NUM_PHASES = 7;
    localparam int WORDS_PER_PHASE = 236;

    // running siphash of the message stream and the digests still owed by the unit
    class digest_book;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [63:0] lane [4];
        logic [7:0]  msg_len;
        logic [63:0] digests_due [$];
        int          errors;
        int          words_seen;
        int          digests_checked;

        function new();
            key_lo = '0;
            key_hi = '0;
            errors = 0;
            words_seen = 0;
            digests_checked = 0;
            restart();
        endfunction

        function void restart();
            lane[0] = key_lo ^ SEED_A;
            lane[1] = key_hi ^ SEED_B;
            lane[2] = key_lo ^ SEED_C;
            lane[3] = key_hi ^ SEED_D;
            msg_len = '0;
        endfunction

        function logic [63:0] rot_left(logic [63:0] x, int unsigned r);
            logic [127:0] d;
            d = {x, x} << r;
            return d[127:64];
        endfunction

        function void mix_round();
            lane[0] = lane[0] + lane[1];
            lane[1] = rot_left(lane[1], 13) ^ lane[0];
            lane[0] = rot_left(lane[0], 32);
            lane[2] = lane[2] + lane[3];
            lane[3] = rot_left(lane[3], 16) ^ lane[2];
            lane[0] = lane[0] + lane[3];
            lane[3] = rot_left(lane[3], 21) ^ lane[0];
            lane[2] = lane[2] + lane[1];
            lane[1] = rot_left(lane[1], 17) ^ lane[2];
            lane[2] = rot_left(lane[2], 32);
        endfunction

        function void compress(logic [63:0] m);
            lane[3] = lane[3] ^ m;
            mix_round();
            mix_round();
            lane[0] = lane[0] ^ m;
        endfunction

        function void load_key(cfg_idx_t idx, logic [63:0] value);
            if (idx == CFG_KEY_LOW)
                key_lo = value;
            else
                key_hi = value;
            restart();
        endfunction

        function void take_word(logic [63:0] w, logic [3:0] nbytes, logic is_last);
            logic [63:0] tail;
            int unsigned cnt;
            words_seen++;
            if (!is_last) begin
                compress(w);
                msg_len = msg_len + 8'd8;
                return;
            end
            cnt = (nbytes > 4'd8) ? 8 : int'(nbytes);
            if (cnt == 8) begin
                // full last word goes in as a normal block, length block follows
                compress(w);
                msg_len = msg_len + 8'd8;
                tail = '0;
            end else begin
                tail = (cnt == 0) ? '0 : (w & (ALL_ONES >> (64 - 8 * cnt)));
                msg_len = msg_len + 8'(cnt);
            end
            tail[63:56] = msg_len;
            compress(tail);
            lane[2] = lane[2] ^ FINISH_MARK;
            repeat (4) mix_round();
            digests_due.push_back(lane[0] ^ lane[1] ^ lane[2] ^ lane[3]);
            restart();
        endfunction

        function void match_digest(logic [63:0] actual);
            logic [63:0] want;
            if (digests_due.size() == 0) begin
                $error("digest: expected none, actual %h", actual);
                errors++;
                return;
            end
            want = digests_due.pop_front();
            digests_checked++;
            if (actual !== want) begin
                $error("digest: expected %h, actual %h", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return digests_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        empty;
    logic        pop;
    logic [63:0] digest;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;

    digest_book book;
    bit         tx_calm;
    bit         rx_calm;
    int         key_settings;

    siphash_2_4_keyed_hash_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .empty        (empty),
        .pop          (pop),
        .digest       (digest),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int tx_gap();
        int r;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    // called at a rising edge; returns at the edge that follows the last idle cycle
    task automatic send_word(input logic [63:0] w, input logic [3:0] nbytes, input logic is_last);
        int gap;
        push <= 1'b1;
        message_word <= w;
        valid_bytes <= nbytes;
        last_word <= is_last;
        do
            @(negedge clk);
        while (full);
        book.take_word(w, nbytes, is_last);
        @(posedge clk);
        gap = tx_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle(input int settle);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_key_regs(input bit do_lo, input logic [63:0] lo,
                                input bit do_hi, input logic [63:0] hi);
        if (do_lo)
        begin
            cfg_index <= CFG_KEY_LOW;
            cfg_data <= lo;
            cfg_we <= 1'b1;
            @(posedge clk);
            book.load_key(CFG_KEY_LOW, lo);
        end
        if (do_hi)
        begin
            cfg_index <= CFG_KEY_HIGH;
            cfg_data <= hi;
            cfg_we <= 1'b1;
            @(posedge clk);
            book.load_key(CFG_KEY_HIGH, hi);
        end
        cfg_we <= 1'b0;
        key_settings++;
    endtask

    // whole messages with random content; the first one of a phase is long enough that it may wrap the length count
    task automatic random_messages(input int target, input bit leave_open);
        int sent;
        int msgs;
        int words;
        logic [3:0] tail_bytes;
        sent = 0;
        msgs = 0;
        while (sent < target)
        begin
            tx_calm = ($urandom_range(0, 5) == 0);
            if (msgs == 0 || $urandom_range(0, 19) == 0)
                words = $urandom_range(30, 40);
            else
                words = $urandom_range(0, 6);
            repeat (words)
            begin
                send_word(pick_word(), 4'($urandom_range(0, 15)), 1'b0);
                sent++;
            end
            if ($urandom_range(0, 99) < 85)
                tail_bytes = 4'($urandom_range(0, 8));
            else
                tail_bytes = 4'($urandom_range(9, 15));
            send_word(pick_word(), tail_bytes, 1'b1);
            sent++;
            msgs++;
            if (msgs == 12)
            begin
                // hold off until the unit has handed back every digest
                push <= 1'b0;
                wait_idle(0);
            end
        end
        if (leave_open)
        begin
            // message cut short by the next key write
            repeat (2) send_word(pick_word(), 4'd8, 1'b0);
        end
        push <= 1'b0;
    endtask

    // digest side: random pop stalls, checked at the falling edge before acceptance
    initial
    begin
        int stall;
        int calm_left;
        pop <= 1'b0;
        stall = 0;
        calm_left = 0;
        rx_calm = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && pop && !empty)
                book.match_digest(digest);
            @(posedge clk);
            if (calm_left == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
                calm_left = 256;
            end
            calm_left--;
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                if (!rx_calm)
                begin
                    if ($urandom_range(0, 99) < 25)
                        stall = $urandom_range(1, 3);
                    else if ($urandom_range(0, 99) < 4)
                        stall = $urandom_range(10, 40);
                end
            end
        end
    end

    initial
    begin
        logic [63:0] lo;
        logic [63:0] hi;
        bit do_lo;
        bit do_hi;
        book = new();
        key_settings = 0;
        tx_calm = 1'b0;
        rst_n <= 1'b0;
        push <= 1'b0;
        message_word <= '0;
        valid_bytes <= '0;
        last_word <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_KEY_LOW;
        cfg_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero key after reset: short messages with tails of 0 to 9, 12 and 15 bytes
        send_word(pick_word(), 4'd0, 1'b1);
        for (int n = 1; n <= 8; n++)
            send_word((n < 8) ? ALL_ONES : {$urandom, $urandom}, 4'(n), 1'b1);
        send_word(ALL_ONES, 4'd9, 1'b1);
        send_word({$urandom, $urandom}, 4'd12, 1'b1);
        send_word(ALL_ONES, 4'd15, 1'b1);
        // byte count on middle words is ignored
        send_word({$urandom, $urandom}, 4'd0, 1'b0);
        send_word({$urandom, $urandom}, 4'd8, 1'b1);
        send_word(ALL_ONES, 4'd15, 1'b0);
        send_word(ALL_ONES, 4'd3, 1'b1);
        send_word('0, 4'd5, 1'b0);
        send_word('0, 4'd0, 1'b1);
        send_word(ALL_ONES, 4'd8, 1'b0);
        send_word(ALL_ONES, 4'd8, 1'b1);
        push <= 1'b0;
        wait_idle(SETTLE_CYCLES);

        for (int p = 1; p <= NUM_PHASES; p++)
        begin
            case (p)
                1: begin do_lo = 1; lo = ALL_ONES; do_hi = 1; hi = ALL_ONES; end
                2: begin do_lo = 1; lo = '0; do_hi = 0; hi = '0; end
                3: begin do_lo = 1; lo = ALL_ONES; do_hi = 1; hi = '0; end
                default:
                begin
                    do_lo = $urandom_range(0, 1);
                    do_hi = !do_lo || ($urandom_range(0, 1) == 1);
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
            endcase
            set_key_regs(do_lo, lo, do_hi, hi);
            random_messages(WORDS_PER_PHASE, (p == 2 || p == 5));
            wait_idle(SETTLE_CYCLES);
        end

        $display("hashed %0d message words into %0d checked digests under %0d key settings",
                 book.words_seen, book.digests_checked, key_settings + 1);
        $display("tails of 0 to 15 bytes, length wrap and abandoned messages included");
        if (book.errors == 0 && book.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/shp_pkg.sv
rtl/shp_front.sv
rtl/shp_core.sv
rtl/shp_outq.sv
rtl/siphash_2_4_keyed_hash_unit.sv
rtl/shp_checker.sv
tb/siphash_2_4_keyed_hash_unit_test.sv
